// File: sv/tile_pixel_fetcher_macros.svh
// Assertion macros for the tile pixel fetcher port checker.
`ifndef TILE_PIXEL_FETCHER_MACROS_SVH
`define TILE_PIXEL_FETCHER_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define TPF_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while rst is high.
`define TPF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/tpf_pkg.sv
// Package for the tile pixel fetcher: constants, register indexes and shared types.
`timescale 1ns / 1ps
package tpf_pkg;

   localparam logic [7:0] LINE_WIDTH = 8'd160;

   localparam logic [3:0] STEP_DUMMY_FIRST = 4'd8;
   localparam logic [3:0] STEP_DUMMY_LAST  = 4'd13;

   localparam logic [4:0] MAP_BASE_HI  = 5'b10011;  // 0x9800 >> 11
   localparam logic [2:0] DATA_BASE_HI = 3'b100;    // 0x8000 >> 13

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] CSR_SCROLL_X        = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCROLL_Y        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_Y          = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_X        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LINE     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_LCD_CONTROL     = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_IN_RANGE = 3'd6;

   localparam logic [7:0] LCD_CONTROL_RESET = 8'h91;

   // lcd_control bit positions
   localparam int LCDC_BG_ON      = 0;
   localparam int LCDC_BG_MAP     = 3;
   localparam int LCDC_TILE_MODE  = 4;
   localparam int LCDC_WINDOW_ON  = 5;
   localparam int LCDC_WINDOW_MAP = 6;

   // action of one fetcher step
   typedef enum logic [2:0] {
      ACT_IDLE_FIRST = 3'd0,
      ACT_MAP_READ   = 3'd1,
      ACT_LOW_READ   = 3'd2,
      ACT_LOW_TAKE   = 3'd3,
      ACT_HIGH_READ  = 3'd4,
      ACT_HIGH_TAKE  = 3'd5,
      ACT_IDLE_LAST  = 3'd6,
      ACT_LOAD       = 3'd7
   } act_type;

   typedef struct packed {
      logic [7:0] scroll_x;
      logic [7:0] scroll_y;
      logic [7:0] line_y;
      logic [7:0] window_x;
      logic [7:0] window_line;
      logic [7:0] lcd_control;
      logic       window_in_range;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      scroll_x:        8'd0,
      scroll_y:        8'd0,
      line_y:          8'd0,
      window_x:        8'd0,
      window_line:     8'd0,
      lcd_control:     LCD_CONTROL_RESET,
      window_in_range: 1'b0
   };

   typedef struct packed {
      logic        read_request;
      logic [15:0] read_address;
      logic        pixel_valid;
      logic [7:0]  pixel_x;
      logic [1:0]  pixel_color;
      logic        line_done;
   } rsp_type;

endpackage

// File: sv/tile_pixel_fetcher.sv
// Top level of the tile pixel fetcher: control registers, input and result registers.
//
//   channel  | direction | handshake          | payload
//   req      | in        | req_valid/stall    | start_line, read_data
//   rsp      | out       | rsp_valid/stall    | read_request .. line_done
//   csr      | in        | csr_write_enable   | csr_index, csr_write_data
//
// One dot per cycle while rsp does not stall: a transfer lands in the input register,
// then the fetch step runs and loads the result register once it is empty or being taken.
// The result register lets a new dot enter while a result waits.
// req_stall rises only when the input register holds a dot and rsp is stalled.
// Reset is synchronous; control registers return to their reset values.
`timescale 1ns / 1ps
module tile_pixel_fetcher
   import tpf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_start_line,
   input  logic [7:0]             req_read_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_read_request,
   output logic [15:0]            rsp_read_address,
   output logic                   rsp_pixel_valid,
   output logic [7:0]             rsp_pixel_x,
   output logic [1:0]             rsp_pixel_color,
   output logic                   rsp_line_done,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   cfg_type    cfg_ff;
   logic       in_valid_ff;
   logic       in_start_ff;
   logic [7:0] in_data_ff;
   logic       out_valid_ff;
   rsp_type    out_ff;
   rsp_type    step_rsp;
   logic       advance;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SCROLL_X:        cfg_ff.scroll_x        <= csr_write_data;
            CSR_SCROLL_Y:        cfg_ff.scroll_y        <= csr_write_data;
            CSR_LINE_Y:          cfg_ff.line_y          <= csr_write_data;
            CSR_WINDOW_X:        cfg_ff.window_x        <= csr_write_data;
            CSR_WINDOW_LINE:     cfg_ff.window_line     <= csr_write_data;
            CSR_LCD_CONTROL:     cfg_ff.lcd_control     <= csr_write_data;
            CSR_WINDOW_IN_RANGE: cfg_ff.window_in_range <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_start_ff <= req_start_line;
         in_data_ff  <= req_read_data;
      end
   end

   tpf_fetch u_fetch (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .step_en    (advance),
      .start_line (in_start_ff),
      .read_data  (in_data_ff),
      .rsp        (step_rsp)
   );

   // result register: load on advance, drop after the transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= step_rsp;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_read_request = out_ff.read_request;
   assign rsp_read_address = out_ff.read_address;
   assign rsp_pixel_valid  = out_ff.pixel_valid;
   assign rsp_pixel_x      = out_ff.pixel_x;
   assign rsp_pixel_color  = out_ff.pixel_color;
   assign rsp_line_done    = out_ff.line_done;

endmodule

// File: sv/tpf_fetch.sv
// Fetcher state and per-dot step logic: tile fetch sequence, shifters and window switch.
`timescale 1ns / 1ps
module tpf_fetch
   import tpf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       step_en,
   input  logic       start_line,
   input  logic [7:0] read_data,
   output rsp_type    rsp
);

   logic [3:0]  fetch_step_ff, fetch_step_in;
   logic [7:0]  pixel_count_ff, pixel_count_in;
   logic [3:0]  pixels_left_ff, pixels_left_in;
   logic [2:0]  drop_count_ff, drop_count_in;
   logic        in_window_ff, in_window_in;
   logic [4:0]  bg_column_ff, bg_column_in;
   logic [4:0]  window_column_ff, window_column_in;
   logic [7:0]  tile_index_ff, tile_index_in;
   logic [7:0]  plane_low_next_ff, plane_low_next_in;
   logic [7:0]  plane_high_next_ff, plane_high_next_in;
   logic [7:0]  shift_low_ff, shift_low_in;
   logic [7:0]  shift_high_ff, shift_high_in;
   logic [15:0] last_address_ff, last_address_in;

   always_comb begin
      logic [3:0]        step_s;
      logic [7:0]        bg_y;
      logic [2:0]        tile_row;
      logic              low_bank;
      logic              win;
      logic signed [9:0] wdiff;
      act_type           act;

      // restart for a new line, then run the same dot normally
      step_s             = start_line ? STEP_DUMMY_FIRST : fetch_step_ff;
      pixel_count_in     = start_line ? 8'd0 : pixel_count_ff;
      pixels_left_in     = start_line ? 4'd0 : pixels_left_ff;
      in_window_in       = start_line ? 1'b0 : in_window_ff;
      bg_column_in       = start_line ? cfg.scroll_x[7:3] : bg_column_ff;
      window_column_in   = start_line ? 5'd0 : window_column_ff;
      drop_count_in      = start_line ? cfg.scroll_x[2:0] : drop_count_ff;
      fetch_step_in      = step_s;
      tile_index_in      = tile_index_ff;
      plane_low_next_in  = plane_low_next_ff;
      plane_high_next_in = plane_high_next_ff;
      shift_low_in       = shift_low_ff;
      shift_high_in      = shift_high_ff;
      last_address_in    = last_address_ff;

      bg_y     = cfg.line_y + cfg.scroll_y;
      tile_row = in_window_in ? cfg.window_line[2:0] : bg_y[2:0];
      low_bank = 1'b0;
      win      = 1'b0;
      wdiff    = '0;
      act      = ACT_IDLE_LAST;
      rsp      = '0;

      if (pixel_count_in < LINE_WIDTH) begin
         if (!step_s[3]) begin
            act           = act_type'(step_s[2:0]);
            fetch_step_in = {1'b0, step_s[2:0] + 3'd1};
         end else if (step_s <= STEP_DUMMY_LAST) begin
            act           = act_type'(step_s[2:0]);
            fetch_step_in = (step_s == STEP_DUMMY_LAST) ? 4'd0 : step_s + 4'd1;
         end else begin
            act           = ACT_IDLE_LAST;
            fetch_step_in = 4'd0;
         end

         unique case (act)
            ACT_MAP_READ: begin
               if (in_window_in)
                  last_address_in = {MAP_BASE_HI, cfg.lcd_control[LCDC_WINDOW_MAP],
                                     cfg.window_line[7:3], window_column_in};
               else
                  last_address_in = {MAP_BASE_HI, cfg.lcd_control[LCDC_BG_MAP],
                                     bg_y[7:3], bg_column_in};
               rsp.read_request = 1'b1;
               rsp.read_address = last_address_in;
            end
            ACT_LOW_READ: begin
               tile_index_in = read_data;
               // signed tile mode puts tiles 0..127 in the upper bank
               low_bank = !cfg.lcd_control[LCDC_TILE_MODE] && !read_data[7];
               last_address_in  = {DATA_BASE_HI, low_bank, read_data, tile_row, 1'b0};
               rsp.read_request = 1'b1;
               rsp.read_address = last_address_in;
            end
            ACT_LOW_TAKE: plane_low_next_in = read_data;
            ACT_HIGH_READ: begin
               last_address_in  = last_address_ff + 16'd1;
               rsp.read_request = 1'b1;
               rsp.read_address = last_address_in;
            end
            ACT_HIGH_TAKE: plane_high_next_in = read_data;
            ACT_LOAD: begin
               if (in_window_in)
                  window_column_in = window_column_in + 5'd1;
               else
                  bg_column_in = bg_column_in + 5'd1;
               // drop the leading pixels of the first tile for fine scroll
               shift_low_in   = plane_low_next_ff << drop_count_in;
               shift_high_in  = plane_high_next_ff << drop_count_in;
               pixels_left_in = 4'd8 - {1'b0, drop_count_in};
               drop_count_in  = 3'd0;
            end
            ACT_IDLE_FIRST, ACT_IDLE_LAST: ;
            default: ;
         endcase

         if (pixels_left_in != 4'd0) begin
            rsp.pixel_valid = 1'b1;
            rsp.pixel_x     = pixel_count_in;
            if (cfg.lcd_control[LCDC_BG_ON])
               rsp.pixel_color = {shift_high_in[7], shift_low_in[7]};
            pixel_count_in = pixel_count_in + 8'd1;
            pixels_left_in = pixels_left_in - 4'd1;
            shift_low_in   = {shift_low_in[6:0], 1'b0};
            shift_high_in  = {shift_high_in[6:0], 1'b0};
            wdiff = $signed({2'b00, pixel_count_in}) - $signed({2'b00, cfg.window_x});
            win = cfg.lcd_control[LCDC_WINDOW_ON] && cfg.window_in_range &&
                  (in_window_in ? (wdiff > $signed({2'b00, LINE_WIDTH}))
                                : (pixel_count_in >= cfg.window_x));
            // switch source: flush the shifters and restart the fetch
            if (win != in_window_in) begin
               in_window_in   = win;
               pixels_left_in = 4'd0;
               drop_count_in  = 3'd0;
               fetch_step_in  = 4'd0;
            end
         end
      end

      rsp.line_done = (pixel_count_in >= LINE_WIDTH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fetch_step_ff      <= STEP_DUMMY_FIRST;
         pixel_count_ff     <= '0;
         pixels_left_ff     <= '0;
         drop_count_ff      <= '0;
         in_window_ff       <= 1'b0;
         bg_column_ff       <= '0;
         window_column_ff   <= '0;
         tile_index_ff      <= '0;
         plane_low_next_ff  <= '0;
         plane_high_next_ff <= '0;
         shift_low_ff       <= '0;
         shift_high_ff      <= '0;
         last_address_ff    <= '0;
      end else if (step_en) begin
         fetch_step_ff      <= fetch_step_in;
         pixel_count_ff     <= pixel_count_in;
         pixels_left_ff     <= pixels_left_in;
         drop_count_ff      <= drop_count_in;
         in_window_ff       <= in_window_in;
         bg_column_ff       <= bg_column_in;
         window_column_ff   <= window_column_in;
         tile_index_ff      <= tile_index_in;
         plane_low_next_ff  <= plane_low_next_in;
         plane_high_next_ff <= plane_high_next_in;
         shift_low_ff       <= shift_low_in;
         shift_high_ff      <= shift_high_in;
         last_address_ff    <= last_address_in;
      end
   end

endmodule

// File: sv/tpf_port_checker.sv
// Port-level checker for the tile pixel fetcher, bound to the top level.
`timescale 1ns / 1ps
`include "tile_pixel_fetcher_macros.svh"
module tpf_port_checker
   import tpf_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic                   rsp_read_request,
   input logic [15:0]            rsp_read_address,
   input logic                   rsp_pixel_valid,
   input logic [7:0]             rsp_pixel_x,
   input logic [1:0]             rsp_pixel_color
);

   `TPF_ASSERT_IMPLY(a_addr_in_vram, clock, reset, rsp_valid && rsp_read_request, rsp_read_address[15:13] == DATA_BASE_HI, "read address outside video memory")
   `TPF_ASSERT_IMPLY(a_idle_pixel_zero, clock, reset, rsp_valid && !rsp_pixel_valid, rsp_pixel_x == 8'd0 && rsp_pixel_color == 2'd0, "pixel fields set without a pixel")
   `TPF_ASSERT_IMPLY(a_pixel_on_screen, clock, reset, rsp_valid && rsp_pixel_valid, rsp_pixel_x < LINE_WIDTH, "pixel column past line width")
   `TPF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_pixel_x) && $stable(rsp_read_address), "stalled result changed")

endmodule

bind tile_pixel_fetcher tpf_port_checker u_port_checker (.*);
